// ===== hdl/sitda_pkg.sv =====
`timescale 1ns / 1ps

package sitda_pkg;

  // Width of the signed input value.
  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1).
  // The ratio 1233/4096 lies just below log10(2).
  localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;

  localparam int DIG_IDX_W = $clog2(DIGITS);
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } sitda_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } sitda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic negative;
    logic digit_last;
    logic out_free;
  } sitda_stat_t;

endpackage

// ===== hdl/sitda_ctrl.sv =====
`timescale 1ns / 1ps

module sitda_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sitda_pkg::sitda_stat_t stat_i,
  output sitda_pkg::sitda_cmd_t  cmd_o
);
  import sitda_pkg::*;

  sitda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (stat_i.conv_done) state_d = stat_i.negative ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (stat_i.out_free) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (stat_i.out_free && stat_i.digit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
      end
      ST_SIGN: begin
        cmd_o.emit_sign = stat_i.out_free;
      end
      ST_DIGIT: begin
        cmd_o.emit_digit = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/sitda_dp.sv =====
`timescale 1ns / 1ps

module sitda_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value_i,
  input  sitda_pkg::sitda_cmd_t                cmd_i,
  output sitda_pkg::sitda_stat_t               stat_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [7:0]                           text_char_o,
  output logic                                 last_o
);
  import sitda_pkg::*;

  logic [VALUE_WIDTH-1:0]        mag_q, mag_d;
  logic [DIGITS-1:0][3:0]        bcd_q, bcd_d;
  logic [DIGITS-1:0][3:0]        adj;
  logic [DIGITS*4-1:0]           adj_flat;
  logic [BIT_CNT_W-1:0]          cnt_q, cnt_d;
  logic [DIG_IDX_W-1:0]          idx_q, idx_d;
  logic [DIG_IDX_W-1:0]          top_idx;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    char_q, char_d;
  logic                          last_q, last_d;
  logic [VALUE_WIDTH-1:0]        value_u;
  logic                          conv_done;

  assign value_u   = value_i;
  assign conv_done = (cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1));

  // Shift-and-add-3 step: correct every digit, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign adj_flat = adj;

  // Highest nonzero digit of the finished result; zero shows as one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_d[i] != 4'd0) top_idx = DIG_IDX_W'(i);
    end
  end

  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      neg_d = value_u[VALUE_WIDTH-1];
      mag_d = value_u[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value_u) : value_u;
      bcd_d = '0;
      cnt_d = '0;
    end else if (cmd_i.shift) begin
      bcd_d = {adj_flat[DIGITS*4-2:0], mag_q[VALUE_WIDTH-1]};
      mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + BIT_CNT_W'(1);
      if (conv_done) idx_d = top_idx;
    end else if (cmd_i.emit_digit) begin
      idx_d = idx_q - DIG_IDX_W'(1);
    end
  end

  always_comb begin
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit_sign) begin
      char_d      = CHAR_MINUS;
      last_d      = 1'b0;
      out_valid_d = 1'b1;
    end else if (cmd_i.emit_digit) begin
      char_d      = CHAR_ZERO + {4'd0, bcd_q[idx_q]};
      last_d      = (idx_q == '0);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign stat_o.conv_done  = conv_done;
  assign stat_o.negative   = neg_q;
  assign stat_o.digit_last = (idx_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== hdl/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     value_i (signed, VALUE_WIDTH bits)
// out      output     out_valid_o / out_ready_i   text_char_o (8 bits), last_o
//
// An item is accepted in the idle state, converted by bit-serial shift-and-add-3
// binary to BCD conversion of its magnitude, then sent out one character at a
// time, an optional minus sign first and then the digits, most significant first.
// Reset is asynchronous and active low; it clears the controller and the output
// valid flag. A stall on the output holds the character sequencer; the next item
// is accepted while the final character of the previous one still waits.

module signed_int_to_decimal_ascii_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [7:0]                               text_char_o,
  output logic                                     last_o
);
  import sitda_pkg::*;

  // The controller sequences load, conversion, the optional minus sign and the
  // digits; the datapath holds the magnitude, the BCD digits and the output
  // register that decouples the two channels.
  sitda_cmd_t  cmd;
  sitda_stat_t stat;

  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sitda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

endmodule

// ===== hdl/sitda_checker.sv =====
`timescale 1ns / 1ps

module sitda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] text_char_o,
  input logic       last_o
);
  import sitda_pkg::*;

  // A waiting character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(text_char_o) && $stable(last_o)))
    else $error("output item changed while stalled");

  // Only a minus sign or a decimal digit is ever shown.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (text_char_o == CHAR_MINUS ||
                     (text_char_o >= CHAR_ZERO && text_char_o <= CHAR_NINE)))
    else $error("illegal character");

  // The minus sign never ends a run.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_char_o == CHAR_MINUS) |-> !last_o)
    else $error("minus sign flagged last");

  // After an item is taken, the block is busy converting it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after accept");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);

// ===== dv/signed_int_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 1ps

// Testbench for signed_int_to_decimal_ascii_core.
//
// Every accepted input value is converted to its decimal text by the function
// predict_text() and queued as expected characters. The output monitor pops
// one expected character per accepted output item and compares the character
// and the last flag. The stimulus covers field extremes, all digit counts and
// both signs, random values, a long output hold-off that backs the core up into
// its input, a sender pause that lets the core drain, and a final gap-free run.

module signed_int_to_decimal_ascii_core_tb;
  import sitda_pkg::*;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // One output item: a character and its end-of-text flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // Quiet cycles after the last expected character, so that a stray trailing
  // character would still be caught.
  localparam int DRAIN_CYCLES = 64;
  // A value yields at most 11 characters, each of which may wait behind a random
  // output stall, after a random sender gap; the limit covers that many times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 300;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  value_t     value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] text_char_o;
  logic       last_o;

  text_char_t pending_chars_q[$];

  bit idle_en       = 1'b1;
  int hold_request  = 0;
  int error_count   = 0;
  int values_sent   = 0;
  int negatives     = 0;
  int chars_checked = 0;
  int in_stalls     = 0;
  int long_holds    = 0;
  int cycle_count   = 0;

  signed_int_to_decimal_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Runaway guard. It is the only other place that ends the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d characters still expected",
             cycle_count, pending_chars_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // Decimal text of one value. The magnitude is taken one bit wider than the
  // value so that the most negative value keeps its true magnitude.
  function automatic void predict_text(input value_t v);
    logic [VALUE_WIDTH:0] mag;
    logic [7:0]           digits[$];
    text_char_t           c;
    bit                   neg;
    neg = v[VALUE_WIDTH-1];
    mag = neg ? (~{1'b1, v}) + 1'b1 : {1'b0, v};
    do begin
      digits.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      pending_chars_q.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch   = digits[i];
      c.last = (i == digits.size() - 1);
      pending_chars_q.push_back(c);
    end
  endfunction

  // Offers one value and returns at the edge where it is accepted. Valid is
  // left high there, so a back-to-back item needs no second assignment in that
  // step; a gap lowers it first.
  task automatic send_value(input value_t v);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) begin
      in_stalls++;
      @(posedge clk_i);
    end
    predict_text(v);
    values_sent++;
    if (v < 0) negatives++;
  endtask

  // Lowers valid and waits until every expected character has come out, then
  // a little longer so that a stray character would still be caught.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_chars_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Draws a value: fully random bits, a random value of a chosen digit count,
  // or a neighbor of a power of ten, each with a random sign.
  function automatic value_t random_value();
    longint mag;
    longint lo;
    longint hi;
    int     ndig;
    ndig = $urandom_range(1, 10);
    case ($urandom_range(0, 2))
      0: begin
        return value_t'($urandom);
      end
      1: begin
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = lo + $urandom_range(0, 32'(hi - lo));
      end
      default: begin
        mag = 1;
        for (int i = 1; i < ndig; i++) mag = mag * 10;
        mag = mag + $urandom_range(0, 2) - 1;
      end
    endcase
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return value_t'(mag);
  endfunction

  // Output side: checks each accepted character against the oldest expected
  // one, then chooses ready for the next cycle. Random stall bursts run while
  // idling is enabled; a long hold-off is requested by the test sequence.
  initial begin
    int         stall_left;
    text_char_t exp_c;
    stall_left = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        chars_checked++;
        if (pending_chars_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                    text_char_o, last_o));
        end else begin
          exp_c = pending_chars_q.pop_front();
          if (text_char_o !== exp_c.ch)
            report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                      text_char_o, exp_c.ch));
          if (last_o !== exp_c.last)
            report_mismatch($sformatf("last %0b, expected %0b on 0x%02h",
                                      last_o, exp_c.last, exp_c.ch));
        end
      end
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
        long_holds++;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Zero, one digit, the digit count boundaries at 10, 100 and 10**9, both
  // extremes of the field, the most negative value and alternating bit patterns.
  task automatic test_directed_values();
    value_t vmax;
    value_t vmin;
    vmax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    vmin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    send_value('0);
    send_value(value_t'(1));
    send_value(value_t'(-1));
    send_value(value_t'(9));
    send_value(value_t'(10));
    send_value(value_t'(-10));
    send_value(value_t'(99));
    send_value(value_t'(100));
    send_value(value_t'(-7));
    send_value(vmax);
    send_value(vmin);
    send_value(vmin + 1);
    send_value(value_t'(1234567890));
    send_value(value_t'(-1000000000));
    send_value(value_t'(1000000000));
    send_value(value_t'(999999999));
    send_value(value_t'(-999999999));
    send_value({(VALUE_WIDTH/2){2'b01}});
    send_value({(VALUE_WIDTH/2){2'b10}});
    send_value(value_t'(-8));
    drain_outputs();
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(random_value());
    drain_outputs();
  endtask

  // The output holds off for a long stretch while values keep coming, so the
  // core fills up and must stall its input.
  task automatic test_output_backpressure();
    idle_en      = 1'b0;
    hold_request = LONG_HOLD_CYCLES;
    repeat (8) send_value(random_value());
    idle_en = 1'b1;
    drain_outputs();
  endtask

  // The sender stops until the core has delivered everything, then resumes.
  task automatic test_sender_pause();
    repeat (6) send_value(random_value());
    drain_outputs();
    repeat (6) send_value(random_value());
    drain_outputs();
  endtask

  // No idling on either side for the closing run.
  task automatic test_streaming_run(input int count);
    idle_en = 1'b0;
    repeat (count) send_value(random_value());
    drain_outputs();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    value_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_values(300);
    test_output_backpressure();
    test_sender_pause();
    test_streaming_run(30);

    $display("Converted %0d values (%0d negative), checked %0d characters.",
             values_sent, negatives, chars_checked);
    $display("Input stalled %0d cycles; %0d long output hold-off(s); %0d mismatches.",
             in_stalls, long_holds, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
